// File: src/lfp_pkg.sv
// shared types and constants of the led frame packer
package lfp_pkg;

  typedef logic [7:0] byte_t;

  // request commands
  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_STRIP = 2'd1,
    CMD_FRAME = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // packet framing bytes
  localparam byte_t MARK_START = 8'd94;
  localparam byte_t MARK_END   = 8'd36;
  localparam byte_t MARK_STRIP = 8'd44;

  // escape table entries
  localparam byte_t ESC_ZERO_IN    = 8'd0;
  localparam byte_t ESC_ZERO_OUT   = 8'd1;
  localparam byte_t ESC_CARET_IN   = 8'd94;
  localparam byte_t ESC_CARET_OUT  = 8'd95;
  localparam byte_t ESC_COMMA_IN   = 8'd44;
  localparam byte_t ESC_COMMA_OUT  = 8'd43;
  localparam byte_t ESC_DOLLAR_IN  = 8'd36;
  localparam byte_t SUBST_RESET    = 8'd37;

  // one escape lane per input channel: red, green, blue and brightness
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned CNT_W     = $clog2(NUM_LANES + 1);

  // framing read classes
  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_START = 2'd1,
    RD_BODY  = 2'd2,
    RD_END   = 2'd3
  } rd_sel_e;

endpackage

// File: src/led_frame_packer_with_change_detect_core.sv
// top level of the led frame packer with change detection
// one request at a time: new requests stall until the result of the current one is handed over;
// the single write port of the byte store takes one escaped byte per cycle
// the four escape lanes run in parallel; a merge stage streams their bytes into the store
// reset clears all control state and flags; the byte store itself is not cleared
module led_frame_packer_with_change_detect_core #(
  parameter int unsigned FRAME_BYTES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [7:0]           brightness_i,
  input  logic [10:0]          read_index_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_byte_o,
  output logic                 changed_o,
  output logic [10:0]          packet_length_o,
  output logic                 overflow_o
);
  import lfp_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CW = ((PW > 11) ? PW : 11) + 1;
  localparam logic [PW-1:0] FB = PW'(FRAME_BYTES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BYTES = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // control state
  logic [1:0]       state_q, state_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [PW-1:0]    prev_len_q, prev_len_d;
  logic             have_prev_q, have_prev_d;
  logic             differs_q, differs_d;
  logic             changed_q, changed_d;
  logic             ovf_q, ovf_d;
  byte_t            subst_q, subst_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wb_valid_q, wb_valid_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  byte_t            buf_q [NUM_LANES];
  byte_t            buf_d [NUM_LANES];
  logic [AW-1:0]    wb_addr_q, wb_addr_d;
  byte_t            wb_byte_q, wb_byte_d;
  logic             wb_cmp_q, wb_cmp_d;
  cmd_e             cmd_q, cmd_d;
  rd_sel_e          rd_sel_q, rd_sel_d;
  logic             res_ovf_q, res_ovf_d;
  byte_t            res_byte_q, res_byte_d;
  byte_t            o_byte_q, o_byte_d;
  logic             o_changed_q, o_changed_d;
  logic [10:0]      o_len_q, o_len_d;
  logic             o_ovf_q, o_ovf_d;

  // ram signals
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  byte_t            ram_wdata, ram_rdata;

  // lanes
  byte_t            lane_in  [NUM_LANES];
  byte_t            lane_esc [NUM_LANES];

  logic             in_accept;
  logic             out_free;
  logic [CW-1:0]    idx_ext, len_ext, idx_m1;

  assign lane_in[0] = red_i;
  assign lane_in[1] = green_i;
  assign lane_in[2] = blue_i;
  assign lane_in[3] = brightness_i;

  // parallel escape lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lfp_esc_lane u_lane (
      .value_i (lane_in[g]),
      .subst_i (subst_q),
      .esc_o   (lane_esc[g])
    );
  end

  // packet byte store
  lfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign idx_ext = CW'(read_index_i);
  assign len_ext = CW'(prev_len_q);
  assign idx_m1  = idx_ext - CW'(1);

  // sequencer, merge stage and change tracking
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    prev_len_d  = prev_len_q;
    have_prev_d = have_prev_q;
    differs_d   = differs_q;
    changed_d   = changed_q;
    ovf_d       = ovf_q;
    subst_d     = subst_q;
    cnt_d       = cnt_q;
    buf_d       = buf_q;
    wb_valid_d  = 1'b0;
    wb_addr_d   = wb_addr_q;
    wb_byte_d   = wb_byte_q;
    wb_cmp_d    = wb_cmp_q;
    cmd_d       = cmd_q;
    rd_sel_d    = rd_sel_q;
    res_ovf_d   = res_ovf_q;
    res_byte_d  = res_byte_q;
    out_valid_d = out_valid_q;
    o_byte_d    = o_byte_q;
    o_changed_d = o_changed_q;
    o_len_d     = o_len_q;
    o_ovf_d     = o_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = wb_addr_q;
    ram_wdata   = wb_byte_q;
    ram_re      = 1'b0;
    ram_raddr   = wp_q[AW-1:0];

    if (cfg_we_i) begin
      subst_d = cfg_data_i;
    end

    // write-back: compare old byte, then overwrite
    if (wb_valid_q) begin
      ram_we = 1'b1;
      if (wb_cmp_q && (ram_rdata != wb_byte_q)) begin
        differs_d = 1'b1;
      end
    end

    // result register drains when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d      = cmd_e'(command_i);
          res_byte_d = '0;
          case (cmd_e'(command_i))
            CMD_PIXEL: begin
              buf_d   = lane_esc;
              cnt_d   = CNT_W'(NUM_LANES);
              state_d = ST_BYTES;
            end
            CMD_STRIP: begin
              buf_d[0] = MARK_STRIP;
              cnt_d    = CNT_W'(1);
              state_d  = ST_BYTES;
            end
            CMD_FRAME: begin
              changed_d   = !have_prev_q || differs_q || (wp_q != prev_len_q);
              prev_len_d  = wp_q;
              have_prev_d = 1'b1;
              res_ovf_d   = ovf_q;
              wp_d        = '0;
              differs_d   = 1'b0;
              ovf_d       = 1'b0;
              state_d     = ST_DONE;
            end
            default: begin
              ram_re    = 1'b1;
              ram_raddr = idx_m1[AW-1:0];
              if (idx_ext == '0) begin
                rd_sel_d = RD_START;
              end else if (idx_ext <= len_ext) begin
                rd_sel_d = RD_BODY;
              end else if (idx_ext == len_ext + CW'(1)) begin
                rd_sel_d = RD_END;
              end else begin
                rd_sel_d = RD_ZERO;
              end
              state_d = ST_READ;
            end
          endcase
        end
      end
      ST_BYTES: begin
        // issue one byte per cycle: read the old byte, write the new byte over it next cycle
        if (cnt_q != '0) begin
          if (wp_q < FB) begin
            ram_re     = 1'b1;
            ram_raddr  = wp_q[AW-1:0];
            wb_valid_d = 1'b1;
            wb_addr_d  = wp_q[AW-1:0];
            wb_byte_d  = buf_q[0];
            wb_cmp_d   = have_prev_q && (wp_q < prev_len_q);
            wp_d       = wp_q + PW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          for (int i = 0; i < NUM_LANES - 1; i++) begin
            buf_d[i] = buf_q[i+1];
          end
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        case (rd_sel_q)
          RD_START: res_byte_d = MARK_START;
          RD_BODY:  res_byte_d = ram_rdata;
          RD_END:   res_byte_d = MARK_END;
          default:  res_byte_d = '0;
        endcase
        state_d = ST_DONE;
      end
      default: begin
        // hand the result over once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          o_byte_d    = res_byte_q;
          o_changed_d = changed_q;
          o_len_d     = len_ext[10:0];
          o_ovf_d     = (cmd_q == CMD_FRAME) ? res_ovf_q : ovf_q;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      prev_len_q  <= '0;
      have_prev_q <= 1'b0;
      differs_q   <= 1'b0;
      changed_q   <= 1'b0;
      ovf_q       <= 1'b0;
      subst_q     <= SUBST_RESET;
      cnt_q       <= '0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      prev_len_q  <= prev_len_d;
      have_prev_q <= have_prev_d;
      differs_q   <= differs_d;
      changed_q   <= changed_d;
      ovf_q       <= ovf_d;
      subst_q     <= subst_d;
      cnt_q       <= cnt_d;
      wb_valid_q  <= wb_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    buf_q       <= buf_d;
    wb_addr_q   <= wb_addr_d;
    wb_byte_q   <= wb_byte_d;
    wb_cmp_q    <= wb_cmp_d;
    cmd_q       <= cmd_d;
    rd_sel_q    <= rd_sel_d;
    res_ovf_q   <= res_ovf_d;
    res_byte_q  <= res_byte_d;
    o_byte_q    <= o_byte_d;
    o_changed_q <= o_changed_d;
    o_len_q     <= o_len_d;
    o_ovf_q     <= o_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign read_byte_o     = o_byte_q;
  assign changed_o       = o_changed_q;
  assign packet_length_o = o_len_q;
  assign overflow_o      = o_ovf_q;

`ifndef SYNTHESIS
  // write position never runs past the store
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= FB)
    else $error("write position beyond store capacity");

  // a write-back only follows a byte issue
  a_wb_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q |-> $past(state_q) == ST_BYTES)
    else $error("write-back without issue");

  // all writes have landed before a result is handed over
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !wb_valid_q)
    else $error("result pending with write in flight");

  // end of frame restarts the body and clears the drop flag
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && command_i == CMD_FRAME) |=> (wp_q == '0 && !ovf_q && have_prev_q))
    else $error("end of frame did not restart the body");
`endif

endmodule

// File: src/lfp_ram.sv
// generic single write port, single read port ram with registered read
module lfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lfp_esc_lane.sv
// one escape lane: maps a channel byte to its packet byte
module lfp_esc_lane (
  input  lfp_pkg::byte_t value_i,
  input  lfp_pkg::byte_t subst_i,
  output lfp_pkg::byte_t esc_o
);
  import lfp_pkg::*;

  // reserved bytes are swapped for other bytes; the dollar byte for the configured substitute
  always_comb begin
    case (value_i)
      ESC_ZERO_IN:   esc_o = ESC_ZERO_OUT;
      ESC_CARET_IN:  esc_o = ESC_CARET_OUT;
      ESC_COMMA_IN:  esc_o = ESC_COMMA_OUT;
      ESC_DOLLAR_IN: esc_o = subst_i;
      default:       esc_o = value_i;
    endcase
  end

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the led frame packer with change detection core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfp_pkg::*;

  localparam int unsigned FRAME_BYTES    = 1024;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  // one request as seen on the input channel
  typedef struct packed {
    cmd_e        cmd;
    byte_t       red;
    byte_t       green;
    byte_t       blue;
    byte_t       brightness;
    logic [10:0] read_index;
  } request_t;

  // one result as seen on the output channel
  typedef struct packed {
    byte_t       read_byte;
    logic        changed;
    logic [10:0] packet_length;
    logic        overflow;
  } packet_status_t;

  // directed stimulus row, optionally with a hand-written expectation
  typedef struct {
    request_t       req;
    int unsigned    reps;
    bit             typed;
    packet_status_t status;
  } stim_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [7:0]  cfg_data_i   = 8'd0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i    = 2'd0;
  logic [7:0]  red_i        = 8'd0;
  logic [7:0]  green_i      = 8'd0;
  logic [7:0]  blue_i       = 8'd0;
  logic [7:0]  brightness_i = 8'd0;
  logic [10:0] read_index_i = 11'd0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [7:0]  read_byte_o;
  logic        changed_o;
  logic [10:0] packet_length_o;
  logic        overflow_o;

  // copy of the packer state kept by the testbench
  byte_t       body_store [FRAME_BYTES];
  int unsigned body_fill     = 0;
  int unsigned last_length   = 0;
  bit          have_last     = 1'b0;
  bit          body_differs  = 1'b0;
  bit          last_changed  = 1'b0;
  bit          bytes_dropped = 1'b0;
  byte_t       dollar_subst  = SUBST_RESET;

  packet_status_t pending_status [$];
  request_t       last_frame [$];
  stim_row_t      directed [$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned sent_items   = 0;
  int unsigned error_count  = 0;
  int unsigned stuck_cycles = 0;
  bit          in_take      = 1'b0;
  bit          out_take     = 1'b0;

  led_frame_packer_with_change_detect_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .brightness_i   (brightness_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_byte_o    (read_byte_o),
    .changed_o      (changed_o),
    .packet_length_o(packet_length_o),
    .overflow_o     (overflow_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // escape one channel byte
  function automatic byte_t escaped(byte_t b);
    case (b)
      ESC_ZERO_IN:   return ESC_ZERO_OUT;
      ESC_CARET_IN:  return ESC_CARET_OUT;
      ESC_COMMA_IN:  return ESC_COMMA_OUT;
      ESC_DOLLAR_IN: return dollar_subst;
      default:       return b;
    endcase
  endfunction

  // append to the body, noting drops and differences from the last frame
  function automatic void store_body_byte(byte_t b);
    if (body_fill >= FRAME_BYTES) begin
      bytes_dropped = 1'b1;
    end else begin
      if (have_last && body_fill < last_length && body_store[body_fill] != b)
        body_differs = 1'b1;
      body_store[body_fill] = b;
      body_fill++;
    end
  endfunction

  // advance the packer state by one request and give the status it reports
  function automatic packet_status_t pack_request(request_t r);
    packet_status_t s;
    int unsigned    idx;
    s   = '0;
    idx = r.read_index;
    case (r.cmd)
      CMD_PIXEL: begin
        store_body_byte(escaped(r.red));
        store_body_byte(escaped(r.green));
        store_body_byte(escaped(r.blue));
        store_body_byte(escaped(r.brightness));
      end
      CMD_STRIP: store_body_byte(MARK_STRIP);
      CMD_FRAME: begin
        last_changed = !have_last || body_differs || body_fill != last_length;
        last_length  = body_fill;
        have_last    = 1'b1;
      end
      CMD_READ: begin
        if (idx == 0)
          s.read_byte = MARK_START;
        else if (idx <= last_length)
          s.read_byte = body_store[idx - 1];
        else if (idx == last_length + 1)
          s.read_byte = MARK_END;
      end
    endcase
    s.changed       = last_changed;
    s.packet_length = 11'(last_length);
    s.overflow      = bytes_dropped;
    // end of frame reports the drop flag and then starts a fresh body
    if (r.cmd == CMD_FRAME) begin
      body_fill     = 0;
      body_differs  = 1'b0;
      bytes_dropped = 1'b0;
    end
    return s;
  endfunction

  // channel byte, biased towards the escaped values and the extremes
  function automatic byte_t rand_channel();
    case ($urandom_range(9))
      0:       return ESC_ZERO_IN;
      1:       return ESC_CARET_IN;
      2:       return ESC_COMMA_IN;
      3:       return ESC_DOLLAR_IN;
      4:       return 8'hff;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // request with random payload; read positions mostly near the packet
  function automatic request_t random_req(cmd_e c);
    request_t    r;
    int unsigned span;
    r.cmd        = c;
    r.red        = rand_channel();
    r.green      = rand_channel();
    r.blue       = rand_channel();
    r.brightness = rand_channel();
    span         = $urandom_range(3);
    if (span < 2)
      r.read_index = 11'($urandom_range(last_length + 1));
    else if (span == 2)
      r.read_index = 11'(last_length + 1 + $urandom_range(2));
    else
      r.read_index = 11'($urandom_range(2047));
    return r;
  endfunction

  function automatic stim_row_t stim(cmd_e c, byte_t rd, byte_t gr, byte_t bl, byte_t bt,
                                     logic [10:0] idx, int unsigned reps);
    stim_row_t row;
    row.req    = '{cmd: c, red: rd, green: gr, blue: bl, brightness: bt, read_index: idx};
    row.reps   = reps;
    row.typed  = 1'b0;
    row.status = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(stim_row_t base, byte_t rb, bit ch,
                                            logic [10:0] len, bit ov);
    base.typed  = 1'b1;
    base.status = '{read_byte: rb, changed: ch, packet_length: len, overflow: ov};
    return base;
  endfunction

  // present one request, hold it until taken, then record its expected status
  task automatic issue(request_t r, bit typed, packet_status_t given);
    packet_status_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= r.cmd;
    red_i        <= r.red;
    green_i      <= r.green;
    blue_i       <= r.blue;
    brightness_i <= r.brightness;
    read_index_i <= r.read_index;
    do @(posedge clk_i); while (!in_take);
    predicted = pack_request(r);
    pending_status = {pending_status, (typed ? given : predicted)};
    sent_items++;
  endtask

  // wait until every expected status has come back
  task automatic drain_results();
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  // one frame: a replay of the last one, a slightly altered one or a fresh one
  task automatic send_frame();
    request_t    items [$];
    int unsigned mode;
    int unsigned n_pix;
    int unsigned pick;
    mode = $urandom_range(9);
    if (mode < 4) begin
      items = last_frame;
    end else if (mode < 6) begin
      items = last_frame;
      if (items.size() == 0) begin
        items = {items, random_req(CMD_STRIP)};
      end else begin
        pick = $urandom_range(items.size() - 1);
        case ($urandom_range(2))
          0:       items[pick] = random_req(CMD_PIXEL);
          1:       void'(items.pop_back());
          default: items = {items, random_req(CMD_PIXEL)};
        endcase
      end
    end else begin
      n_pix = ($urandom_range(39) == 0) ? $urandom_range(250, 270) : $urandom_range(12);
      repeat (n_pix) begin
        items = {items, random_req(CMD_PIXEL)};
        if ($urandom_range(4) == 0)
          items = {items, random_req(CMD_STRIP)};
      end
    end
    // body with stray reads and the odd random command in between
    foreach (items[i]) begin
      if ($urandom_range(7) == 0)
        issue(random_req(CMD_READ), 1'b0, '0);
      if ($urandom_range(29) == 0)
        issue(random_req(cmd_e'($urandom_range(3))), 1'b0, '0);
      issue(items[i], 1'b0, '0);
    end
    issue(random_req(CMD_FRAME), 1'b0, '0);
    last_frame = items;
    if ($urandom_range(1) == 0)
      issue(random_req(CMD_READ), 1'b0, '0);
    // now and then hold off until the block has answered everything
    if ($urandom_range(5) == 0) begin
      in_valid_i <= 1'b0;
      drain_results();
    end
  endtask

  // idle the block, set the substitute byte and idling, then run random frames
  task automatic run_segment(int unsigned send_pct, int unsigned recv_pct, byte_t subst,
                             int unsigned until_items);
    in_valid_i <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_data_i   <= subst;
    cfg_we_i     <= 1'b1;
    send_gap_pct <= send_pct;
    recv_gap_pct <= recv_pct;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    dollar_subst = subst;
    while (sent_items < until_items)
      send_frame();
  endtask

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    error_count++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_gap_pct);
  end

  // sample both handshakes mid-cycle and check each result taken
  always @(negedge clk_i) begin
    packet_status_t want;
    in_take  = in_valid_i && !in_stall_o;
    out_take = rst_ni && out_valid_o && !out_stall_i;
    if (out_take) begin
      if (pending_status.size() == 0) begin
        error_count++;
        $display("%0t ns: result with nothing expected, read_byte %0d length %0d",
                 $time, read_byte_o, packet_length_o);
      end else begin
        want = pending_status.pop_front();
        if (read_byte_o !== want.read_byte)
          report_mismatch("read_byte", want.read_byte, read_byte_o);
        if (changed_o !== want.changed)
          report_mismatch("changed", want.changed, changed_o);
        if (packet_length_o !== want.packet_length)
          report_mismatch("packet_length", want.packet_length, packet_length_o);
        if (overflow_o !== want.overflow)
          report_mismatch("overflow", want.overflow, overflow_o);
      end
    end
  end

  // watchdog on cycles in which nothing moves
  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || in_take || out_take || cfg_we_i)
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("%0t ns: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // main sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni       <= 1'b1;
    send_gap_pct <= 34;
    recv_gap_pct <= 64;
    @(posedge clk_i);

    // directed part: framing, escapes, change decisions, drops
    directed = '{
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 0, 1), MARK_START, 0, 0, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 1, 1), MARK_END, 0, 0, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 2047, 1), 0, 0, 0, 0),
      // all four escapes with the reset substitute
      checked_row(stim(CMD_PIXEL, 0, 94, 44, 36, 0, 1), 0, 0, 0, 0),
      stim(CMD_PIXEL, 255, 255, 255, 255, 2047, 1),
      stim(CMD_STRIP, 255, 255, 255, 255, 2047, 1),
      // first frame always counts as changed
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 1, 1), ESC_ZERO_OUT, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 2, 1), ESC_CARET_OUT, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 3, 1), ESC_COMMA_OUT, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 4, 1), SUBST_RESET, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 9, 1), MARK_STRIP, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 10, 1), MARK_END, 1, 9, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 11, 1), 0, 1, 9, 0),
      // identical frame again
      stim(CMD_PIXEL, 0, 94, 44, 36, 0, 1),
      stim(CMD_PIXEL, 255, 255, 255, 255, 0, 1),
      stim(CMD_STRIP, 0, 0, 0, 0, 0, 1),
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 0, 9, 0),
      // read while a shorter frame is being built
      stim(CMD_PIXEL, 128, 2, 3, 4, 0, 1),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 1, 1), 128, 0, 9, 0),
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 1, 4, 0),
      // empty frames
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 1, 0, 0),
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0),
      // overfill the store, then read its far end
      stim(CMD_PIXEL, 8'haa, 8'haa, 8'haa, 8'haa, 0, 260),
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 1, 1024, 1),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 1025, 1), MARK_END, 1, 1024, 0),
      checked_row(stim(CMD_READ, 0, 0, 0, 0, 1024, 1), 8'haa, 1, 1024, 0),
      checked_row(stim(CMD_STRIP, 0, 0, 0, 0, 0, 1), 0, 1, 1024, 0),
      checked_row(stim(CMD_FRAME, 0, 0, 0, 0, 0, 1), 0, 1, 1, 0)
    };
    foreach (directed[i])
      repeat (directed[i].reps)
        issue(directed[i].req, directed[i].typed, directed[i].status);

    // random frames over several substitute settings and idling patterns
    run_segment(34, 64, 8'd0, 550);
    run_segment(64, 34, 8'd255, 900);
    run_segment(0, 0, ESC_DOLLAR_IN, 1250);
    run_segment(0, 0, byte_t'($urandom_range(255)), 1550);

    in_valid_i <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_status.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
